/* design/ski_pkg.sv */
// shared constants and codes for the sorted key index
// no dependencies

package ski_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W       = 44;
  localparam int REC_W       = 16;
  localparam int ENTRY_W     = KEY_W + REC_W;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 8;
  localparam int COUNT_OUT_W = 9;

  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SEARCH   = 8'b0000_0010,
    S_COMPARE  = 8'b0000_0100,
    S_MATCH    = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_WRITE    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

/* design/ski_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies

module ski_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sorted_key_index.sv */
// sorted key index top level: sequencer, binary search and shift-up insert
// depends on ski_pkg and ski_ram

// A table of up to ski_pkg::TABLE_DEPTH (key, record number) pairs kept in
// ascending key order in one ram. A request is taken when start is high and
// busy is low; busy then stays high up to the cycle in which the result is
// shown, and is low again in that cycle. The
// result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must take it in that cycle. Every request first runs
// a binary search with the single less-than key comparator, each halving
// a ram read, then a compare. A lookup then reads and checks the found slot
// when it lies below the fill count. An insert into a table that is not
// full moves every entry at or above the insert point up by one, each read
// and then written back through the one ram read port, then writes the new
// pair. The result is registered in S_DONE.
// No clearing pass is needed after reset: only slots below the fill count
// are ever read, and all of those have been written.

module sorted_key_index (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic [ski_pkg::KEY_W-1:0]         key,
  input  logic [ski_pkg::REC_W-1:0]         record_number,
  output logic                              done,
  output logic [ski_pkg::STATUS_W-1:0]      status,
  output logic [ski_pkg::REC_W-1:0]         found_record,
  output logic [ski_pkg::SLOT_W-1:0]        slot,
  output logic [ski_pkg::COUNT_OUT_W-1:0]   entry_count
);

  ski_pkg::state_t state, state_next;

  // captured request
  logic                        req_action;
  logic [ski_pkg::KEY_W-1:0]   req_key;
  logic [ski_pkg::REC_W-1:0]   req_rec;

  // search window and shift index, all able to hold the full count
  logic [ski_pkg::CNT_W-1:0]   lo;
  logic [ski_pkg::CNT_W-1:0]   hi;
  logic [ski_pkg::CNT_W-1:0]   idx;
  logic [ski_pkg::CNT_W-1:0]   fill_count;
  logic [ski_pkg::CNT_W-1:0]   mid_full;
  logic [ski_pkg::ADDR_W-1:0]  mid;

  // result staging
  ski_pkg::status_t            res_status;
  logic [ski_pkg::REC_W-1:0]   res_found;

  // ram ports
  logic                        ram_we;
  logic [ski_pkg::ADDR_W-1:0]  ram_wr_addr;
  logic [ski_pkg::ENTRY_W-1:0] ram_wr_data;
  logic                        ram_re;
  logic [ski_pkg::ADDR_W-1:0]  ram_rd_addr;
  logic [ski_pkg::ENTRY_W-1:0] ram_rd_data;
  logic [ski_pkg::KEY_W-1:0]   rd_key;
  logic [ski_pkg::REC_W-1:0]   rd_rec;
  logic [ski_pkg::CNT_W-1:0]   idx_dec;
  logic                        key_less;
  logic                        table_full;

  assign busy       = (state != ski_pkg::S_IDLE);
  assign mid_full   = lo + ((hi - lo) >> 1);
  assign mid        = mid_full[ski_pkg::ADDR_W-1:0];
  assign idx_dec    = idx - 1'b1;
  assign rd_key     = ram_rd_data[ski_pkg::ENTRY_W-1:ski_pkg::REC_W];
  assign rd_rec     = ram_rd_data[ski_pkg::REC_W-1:0];
  // the less-than key comparator used by every search step
  assign key_less   = (rd_key < req_key);
  assign table_full = (fill_count == ski_pkg::CNT_W'(ski_pkg::TABLE_DEPTH));

  ski_ram #(
    .WIDTH (ski_pkg::ENTRY_W),
    .DEPTH (ski_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer and ram control
  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_wr_addr = idx[ski_pkg::ADDR_W-1:0];
    ram_wr_data = ram_rd_data;
    ram_re      = 1'b0;
    ram_rd_addr = mid;
    case (state)
      ski_pkg::S_IDLE: begin
        if (start) begin
          state_next = ski_pkg::S_SEARCH;
        end
      end
      ski_pkg::S_SEARCH: begin
        if (lo < hi) begin
          // probe the middle of the window
          ram_re     = 1'b1;
          state_next = ski_pkg::S_COMPARE;
        end else if (req_action == ski_pkg::ACT_LOOKUP) begin
          if (lo < fill_count) begin
            ram_re      = 1'b1;
            ram_rd_addr = lo[ski_pkg::ADDR_W-1:0];
            state_next  = ski_pkg::S_MATCH;
          end else begin
            state_next = ski_pkg::S_DONE;
          end
        end else if (table_full) begin
          state_next = ski_pkg::S_DONE;
        end else begin
          state_next = ski_pkg::S_SHIFT_RD;
        end
      end
      ski_pkg::S_COMPARE: begin
        state_next = ski_pkg::S_SEARCH;
      end
      ski_pkg::S_MATCH: begin
        state_next = ski_pkg::S_DONE;
      end
      ski_pkg::S_SHIFT_RD: begin
        if (idx > lo) begin
          // fetch the entry just below the hole
          ram_re      = 1'b1;
          ram_rd_addr = idx_dec[ski_pkg::ADDR_W-1:0];
          state_next  = ski_pkg::S_SHIFT_WR;
        end else begin
          state_next = ski_pkg::S_WRITE;
        end
      end
      ski_pkg::S_SHIFT_WR: begin
        // move it up into the hole
        ram_we     = 1'b1;
        state_next = ski_pkg::S_SHIFT_RD;
      end
      ski_pkg::S_WRITE: begin
        ram_we      = 1'b1;
        ram_wr_addr = lo[ski_pkg::ADDR_W-1:0];
        ram_wr_data = {req_key, req_rec};
        state_next  = ski_pkg::S_DONE;
      end
      ski_pkg::S_DONE: begin
        state_next = ski_pkg::S_IDLE;
      end
      default: begin
        state_next = ski_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ski_pkg::S_IDLE;
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ski_pkg::S_DONE);
      if (state == ski_pkg::S_WRITE) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ski_pkg::S_IDLE: begin
        req_action <= action;
        req_key    <= key;
        req_rec    <= record_number;
        lo         <= '0;
        hi         <= fill_count;
        res_found  <= '0;
        res_status <= ski_pkg::ST_OK;
      end
      ski_pkg::S_SEARCH: begin
        idx <= fill_count;
        if (!(lo < hi)) begin
          if (req_action == ski_pkg::ACT_LOOKUP) begin
            if (!(lo < fill_count)) begin
              res_status <= ski_pkg::ST_NOT_FOUND;
            end
          end else if (table_full) begin
            res_status <= ski_pkg::ST_FULL;
          end
        end
      end
      ski_pkg::S_COMPARE: begin
        if (key_less) begin
          lo <= mid_full + 1'b1;
        end else begin
          hi <= mid_full;
        end
      end
      ski_pkg::S_MATCH: begin
        if (rd_key == req_key) begin
          res_found <= rd_rec;
        end else begin
          res_status <= ski_pkg::ST_NOT_FOUND;
        end
      end
      ski_pkg::S_SHIFT_WR: begin
        idx <= idx_dec;
      end
      ski_pkg::S_DONE: begin
        status       <= res_status;
        found_record <= res_found;
        entry_count  <= ski_pkg::COUNT_OUT_W'(fill_count);
        if (res_status == ski_pkg::ST_OK) begin
          slot <= ski_pkg::SLOT_W'(lo);
        end else begin
          slot <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/tb_sorted_key_index.sv */
// self-checking testbench for sorted_key_index: directed and random insert and lookup requests
// depends on ski_pkg and the sorted_key_index rtl; predicts every result from its own table copy

module tb_sorted_key_index;
  import ski_pkg::*;

  // largest thirteen digit client identifier
  localparam logic [KEY_W-1:0] KEY_MAX = 44'd9999999999999;
  // total number of requests the run aims for
  localparam int ITEM_TARGET = 1350;
  // generous bound: every request as a worst case insert plus a long gap, several times over
  localparam int CYCLE_LIMIT = 3_000_000;
  // quiet time after the last result: longer than the slowest insert into a nearly full table
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 64;

  // one result as the block reports it
  typedef struct packed {
    status_t                 status;
    logic [REC_W-1:0]        found_record;
    logic [SLOT_W-1:0]       slot;
    logic [COUNT_OUT_W-1:0]  entry_count;
  } index_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all driven from time zero
  logic                  start = 1'b0;
  logic                  action = ACT_INSERT;
  logic [KEY_W-1:0]      key = '0;
  logic [REC_W-1:0]      record_number = '0;

  // result side
  logic                    busy;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic [REC_W-1:0]        found_record;
  logic [SLOT_W-1:0]       slot;
  logic [COUNT_OUT_W-1:0]  entry_count;

  // predictor's own copy of the sorted table
  logic [KEY_W-1:0]  model_keys [TABLE_DEPTH];
  logic [REC_W-1:0]  model_recs [TABLE_DEPTH];
  int                model_fill = 0;

  // results predicted at request acceptance, oldest first
  index_result_t expected_results[$];
  index_result_t oldest_result;

  // bookkeeping
  int mismatch_count = 0;
  int requests_sent = 0;
  int cycle_count = 0;
  int no_idle_left = 0;
  int inserts_stored = 0;
  int inserts_refused = 0;
  int lookups_hit = 0;
  int lookups_missed = 0;

  sorted_key_index dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .key           (key),
    .record_number (record_number),
    .done          (done),
    .status        (status),
    .found_record  (found_record),
    .slot          (slot),
    .entry_count   (entry_count)
  );

  always #6 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("** sorted_key_index: FAILED **");
      $finish;
    end
  end

  // report the first few mismatches in full, only count the rest
  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
  endfunction

  // work out the result of one request and update the table copy, as the block should
  function automatic index_result_t predict_index_result(action_t act, logic [KEY_W-1:0] k,
                                                         logic [REC_W-1:0] rec);
    index_result_t r;
    int lo;
    int hi;
    int mid;
    int i;
    r.status = ST_OK;
    r.found_record = '0;
    r.slot = '0;
    // lower bound: first position whose key is not less than k
    lo = 0;
    hi = model_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    if (act == ACT_INSERT) begin
      if (model_fill >= TABLE_DEPTH) begin
        // full table: nothing stored
        r.status = ST_FULL;
        inserts_refused++;
      end else begin
        // shift later entries up, new pair goes ahead of any equal keys
        for (i = model_fill; i > lo; i--) begin
          model_keys[i] = model_keys[i-1];
          model_recs[i] = model_recs[i-1];
        end
        model_keys[lo] = k;
        model_recs[lo] = rec;
        model_fill++;
        r.slot = SLOT_W'(lo);
        inserts_stored++;
      end
    end else begin
      // lookup reports the lowest matching position
      if (lo < model_fill && model_keys[lo] == k) begin
        r.found_record = model_recs[lo];
        r.slot = SLOT_W'(lo);
        lookups_hit++;
      end else begin
        r.status = ST_NOT_FOUND;
        lookups_missed++;
      end
    end
    r.entry_count = COUNT_OUT_W'(model_fill);
    return r;
  endfunction

  // result checker and request monitor, sampling pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      // compare before queuing, so a result always meets the oldest request
      if (done) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request waiting, status", '0, status);
        end else begin
          oldest_result = expected_results.pop_front();
          if (oldest_result.status !== status)
            flag_mismatch("status", oldest_result.status, status);
          if (oldest_result.found_record !== found_record)
            flag_mismatch("found_record", oldest_result.found_record, found_record);
          if (oldest_result.slot !== slot)
            flag_mismatch("slot", oldest_result.slot, slot);
          if (oldest_result.entry_count !== entry_count)
            flag_mismatch("entry_count", oldest_result.entry_count, entry_count);
        end
      end
      if (start && !busy)
        expected_results = {expected_results,
                            predict_index_result(action_t'(action), key, record_number)};
    end
  end

  // random key: extremes, a narrow cluster for collisions, or the full decimal range
  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] raw;
    int pick;
    pick = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (pick < 5) return '0;
    else if (pick < 10) return KEY_MAX;
    else if (pick < 30) return KEY_W'($urandom_range(0, 63));
    else return KEY_W'(raw % (64'(KEY_MAX) + 64'd1));
  endfunction

  // key already in the table with the given chance, otherwise a random one
  function automatic logic [KEY_W-1:0] pick_key(int pct_stored);
    if (model_fill > 0 && $urandom_range(0, 99) < pct_stored)
      return model_keys[$urandom_range(0, model_fill - 1)];
    return random_key();
  endfunction

  // after an idle gap if one is drawn, hold start high until busy is low at an edge
  task automatic send_request(input action_t act, input logic [KEY_W-1:0] k,
                              input logic [REC_W-1:0] rec);
    int gap;
    int pick;
    // idle time before the request: mostly short, a few long, some stretches with none
    if (no_idle_left > 0) begin
      no_idle_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) no_idle_left = $urandom_range(20, 40);
      if (pick < 40) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    // start is lowered only when a gap follows, never twice in one step
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    key <= k;
    record_number <= rec;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // drop start so the last request is taken only once, then wait for every predicted result
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // empty table lookups, field extremes, equal keys and misses on a small table
  task automatic test_directed_small_table();
    send_request(ACT_LOOKUP, '0, '0);
    send_request(ACT_LOOKUP, KEY_MAX, 16'hFFFF);
    send_request(ACT_INSERT, 44'd500, 16'd1);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, KEY_MAX, 16'hFFFF);
    // equal keys: each new one goes ahead of the earlier ones
    send_request(ACT_INSERT, 44'd500, 16'd2);
    send_request(ACT_INSERT, 44'd500, 16'd3);
    send_request(ACT_INSERT, 44'd499, 16'h8000);
    send_request(ACT_INSERT, 44'd501, 16'h7FFF);
    send_request(ACT_INSERT, 44'h555_5555_5555, 16'h5555);
    send_request(ACT_INSERT, 44'h8AA_AAAA_AAAA, 16'hAAAA);
    send_request(ACT_LOOKUP, 44'd500, '0);
    send_request(ACT_LOOKUP, '0, 16'hFFFF);
    send_request(ACT_LOOKUP, KEY_MAX, '0);
    send_request(ACT_LOOKUP, 44'd499, '0);
    send_request(ACT_LOOKUP, 44'd501, '0);
    send_request(ACT_LOOKUP, 44'h555_5555_5555, '0);
    send_request(ACT_LOOKUP, 44'h8AA_AAAA_AAAA, '0);
    // misses between stored keys, just above the smallest stored and next to the largest
    send_request(ACT_LOOKUP, 44'd502, '0);
    send_request(ACT_LOOKUP, KEY_MAX - 1, '0);
    send_request(ACT_LOOKUP, 44'd1, '0);
    wait_idle();
  endtask

  // random mix that grows the table until it is full
  task automatic test_random_fill();
    int still_free;
    still_free = TABLE_DEPTH - model_fill;
    while (still_free > 0) begin
      if ($urandom_range(0, 99) < 55) begin
        send_request(ACT_INSERT, pick_key(30), REC_W'($urandom_range(0, 65535)));
        still_free--;
      end else if ($urandom_range(0, 9) == 0) begin
        send_request(ACT_LOOKUP, pick_key(60) + 1'b1, REC_W'($urandom_range(0, 65535)));
      end else begin
        send_request(ACT_LOOKUP, pick_key(60), REC_W'($urandom_range(0, 65535)));
      end
    end
    wait_idle();
  endtask

  // inserts refused by the full table, and lookups at both ends and in the middle
  task automatic test_table_full();
    send_request(ACT_INSERT, '0, 16'hFFFF);
    send_request(ACT_INSERT, KEY_MAX, '0);
    send_request(ACT_INSERT, 44'd500, 16'd9);
    send_request(ACT_LOOKUP, '0, '0);
    send_request(ACT_LOOKUP, KEY_MAX, '0);
    send_request(ACT_LOOKUP, model_keys[TABLE_DEPTH/2], '0);
    wait_idle();
  endtask

  // random requests on the full table until the run reaches its target
  task automatic test_random_full_table();
    logic [KEY_W-1:0] k;
    while (requests_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 30) begin
        send_request(ACT_INSERT, pick_key(40), REC_W'($urandom_range(0, 65535)));
      end else begin
        k = pick_key(65);
        // neighbours of stored keys probe the edges of the search
        if ($urandom_range(0, 9) == 0 && k < KEY_MAX) k = k + 1'b1;
        else if ($urandom_range(0, 9) == 0 && k > 0) k = k - 1'b1;
        send_request(ACT_LOOKUP, k, REC_W'($urandom_range(0, 65535)));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_small_table();
    test_random_fill();
    test_table_full();
    test_random_full_table();

    // drop start, then give any stray result time to show up
    start <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch("results never delivered, count", '0, expected_results.size());

    $display("%0d requests in %0d cycles: %0d inserts stored, %0d refused on a full table",
             requests_sent, cycle_count, inserts_stored, inserts_refused);
    $display("lookups: %0d hits, %0d misses; %0d mismatches", lookups_hit, lookups_missed,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("** sorted_key_index: PASSED **");
    end else begin
      $display("** sorted_key_index: FAILED **");
    end
    $finish;
  end

endmodule
